/* src/u8u16_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

    // Result status codes
    localparam logic [1:0] ST_UNIT    = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_TRUNC   = 2'd3;

    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [20:0] SURR_FIRST   = 21'h00D800;
    localparam logic [20:0] SURR_LAST    = 21'h00DFFF;
    localparam logic [20:0] BMP_LAST     = 21'h00FFFF;
    localparam logic [20:0] SUPP_OFFSET  = 21'h010000;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [15:0] CAP_RESET    = 16'd256;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  status;
        logic [15:0] unit_count;
        logic        last;
    } result_t;

endpackage : u8u16_pkg

`default_nettype wire

/* src/utf8_to_utf16_validating.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                       Direction
// --------  --------------------------------------------  ---------
// in        in_valid, in_ready, data_byte[7:0]             sink
// out       out_valid, out_ready, code_unit[15:0],         source
//           status[1:0], unit_count[15:0], last
// cfg       cfg_wr_en, cfg_wr_data[15:0] (dst_capacity)    sink
//
// One byte is taken per cycle while in_ready is high. A byte is held in the input
// register, then decoded and written into a four-entry result queue that feeds
// the out side. A byte that completes a supplementary code point queues two
// results, so the out side sets the long-run rate: one result per cycle while
// out_ready is high. The input register advances while the queue holds at most
// two results. Reset clears the decoder state, the queue and sets the capacity
// to 256.

module utf8_to_utf16_validating #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      code_unit,
    output logic [1:0]       status,
    output logic [15:0]      unit_count,
    output logic             last,

    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);
    import u8u16_pkg::*;

    // Compare width: holds the unit counter plus two without wrapping.
    localparam int CMP_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Configuration
    logic [15:0] cap_reg;

    // Input register
    logic        stage_valid_reg;
    logic [7:0]  stage_byte_reg;

    // Decoder state
    logic [1:0]            pending_reg, pending_next;
    logic [20:0]           partial_reg, partial_next;
    logic [COUNT_BITS-1:0] units_reg, units_next;
    logic                  discard_reg, discard_next;

    // Result queue
    result_t             q_reg [QDEPTH];
    logic [QPTR_W-1:0]   rd_ptr_reg, wr_ptr_reg;
    logic [QPTR_W:0]     q_count_reg;

    logic        advance;
    logic        pop;
    logic        q_space;
    logic [1:0]  n_res;
    result_t     res0, res1;

    assign q_space   = (q_count_reg <= (QPTR_W+1)'(QDEPTH - 2));
    assign advance   = stage_valid_reg && q_space;
    assign in_ready  = !stage_valid_reg || advance;
    assign out_valid = (q_count_reg != '0);
    assign pop       = out_valid && out_ready;

    assign code_unit  = q_reg[rd_ptr_reg].code_unit;
    assign status     = q_reg[rd_ptr_reg].status;
    assign unit_count = q_reg[rd_ptr_reg].unit_count;
    assign last       = q_reg[rd_ptr_reg].last;

    // Decode one byte against the current sequence state.
    always_comb
    begin
        logic [7:0]            b;
        logic [15:0]           cap_eff;
        logic [CMP_W-1:0]      units_ext;
        logic [CMP_W-1:0]      cap_ext;
        logic [CMP_W-1:0]      plus1;
        logic [CMP_W-1:0]      plus2;
        logic [COUNT_BITS-1:0] units_p1;
        logic [COUNT_BITS-1:0] units_p2;
        logic [20:0]           acc;
        logic [20:0]           cp;
        logic [19:0]           supp;
        logic                  do_emit;

        b         = stage_byte_reg;
        cap_eff   = (cap_reg == '0) ? 16'd1 : cap_reg;
        units_ext = CMP_W'(units_reg);
        cap_ext   = CMP_W'(cap_eff);
        plus1     = units_ext + CMP_W'(1);
        plus2     = units_ext + CMP_W'(2);
        // Counter values after one or two units, wrapped at the counter width
        units_p1  = units_reg + COUNT_BITS'(1);
        units_p2  = units_reg + COUNT_BITS'(2);
        acc       = {partial_reg[14:0], b[5:0]};
        cp        = '0;
        supp      = '0;
        do_emit   = 1'b0;

        pending_next = pending_reg;
        partial_next = partial_reg;
        units_next   = units_reg;
        discard_next = discard_reg;
        n_res        = 2'd0;

        res0 = '{code_unit: 16'd0, status: ST_UNIT,
                 unit_count: units_ext[15:0], last: 1'b1};
        res1 = '{code_unit: 16'd0, status: ST_UNIT,
                 unit_count: units_ext[15:0], last: 1'b0};

        if (discard_reg) begin
            // Drop bytes up to and including the terminator.
            if (b == 8'd0) begin
                discard_next = 1'b0;
                pending_next = '0;
                partial_next = '0;
                units_next   = '0;
            end
        end else if (pending_reg == 2'd0) begin
            if (b == 8'd0) begin
                n_res          = 2'd1;
                res0.status    = ST_OK;
                discard_next   = 1'b0;
            end else if (plus1 >= cap_ext) begin
                n_res          = 2'd1;
                res0.status    = ST_TRUNC;
                discard_next   = 1'b1;
            end else begin
                unique case (b) inside
                    8'b0???????: begin
                        cp      = {13'd0, b};
                        do_emit = 1'b1;
                    end
                    8'b110?????: begin
                        partial_next = {16'd0, b[4:0]};
                        pending_next = 2'd1;
                    end
                    8'b1110????: begin
                        partial_next = {17'd0, b[3:0]};
                        pending_next = 2'd2;
                    end
                    8'b11110???: begin
                        partial_next = {18'd0, b[2:0]};
                        pending_next = 2'd3;
                    end
                    default: begin
                        n_res        = 2'd1;
                        res0.status  = ST_INVALID;
                        discard_next = 1'b1;
                    end
                endcase
            end
        end else begin
            if (b[7:6] != 2'b10) begin
                // A zero byte here ends the string: nothing left to drop.
                n_res        = 2'd1;
                res0.status  = ST_INVALID;
                discard_next = (b != 8'd0);
            end else if (pending_reg != 2'd1) begin
                partial_next = acc;
                pending_next = pending_reg - 2'd1;
            end else begin
                cp           = acc;
                do_emit      = 1'b1;
                pending_next = '0;
                partial_next = '0;
            end
        end

        if (do_emit) begin
            if (cp <= BMP_LAST) begin
                if (cp >= SURR_FIRST && cp <= SURR_LAST) begin
                    n_res        = 2'd1;
                    res0.status  = ST_INVALID;
                    discard_next = 1'b1;
                end else begin
                    n_res          = 2'd1;
                    res0.code_unit = cp[15:0];
                    res0.unit_count = 16'(units_p1);
                    res0.last      = 1'b0;
                    units_next     = units_p1;
                end
            end else if (cp <= CP_MAX) begin
                if (plus2 >= cap_ext) begin
                    n_res        = 2'd1;
                    res0.status  = ST_TRUNC;
                    discard_next = 1'b1;
                end else begin
                    supp            = 20'(cp - SUPP_OFFSET);
                    n_res           = 2'd2;
                    res0.code_unit  = HI_SURR_BASE | {6'd0, supp[19:10]};
                    res0.unit_count = 16'(units_p1);
                    res0.last       = 1'b0;
                    res1.code_unit  = LO_SURR_BASE | {6'd0, supp[9:0]};
                    res1.unit_count = 16'(units_p2);
                    units_next      = units_p2;
                end
            end else begin
                n_res        = 2'd1;
                res0.status  = ST_INVALID;
                discard_next = 1'b1;
            end
        end

        // Any status closes the string: clear sequence and count.
        if (n_res == 2'd1 && res0.last) begin
            pending_next = '0;
            partial_next = '0;
            units_next   = '0;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg         <= CAP_RESET;
            stage_valid_reg <= 1'b0;
            pending_reg     <= '0;
            partial_reg     <= '0;
            units_reg       <= '0;
            discard_reg     <= 1'b0;
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            q_count_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (in_ready) begin
                stage_valid_reg <= in_valid;
            end
            if (advance) begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
                units_reg   <= units_next;
                discard_reg <= discard_next;
                wr_ptr_reg  <= wr_ptr_reg + QPTR_W'(n_res);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            q_count_reg <= q_count_reg
                         + ((QPTR_W+1)'(advance ? n_res : 2'd0))
                         - ((QPTR_W+1)'(pop));
        end
    end

    // Payload: input byte and queue entries
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            stage_byte_reg <= data_byte;
        end
        if (advance && n_res != 2'd0) begin
            q_reg[wr_ptr_reg] <= res0;
        end
        if (advance && n_res == 2'd2) begin
            q_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
        end
    end

endmodule : utf8_to_utf16_validating

`default_nettype wire

/* bench/tb_utf8_to_utf16_validating.sv */
`timescale 1ns / 1ps

module tb_utf8_to_utf16_validating;

    import u8u16_pkg::*;

    // Bytes per random phase, settle time after the last awaited result, and
    // the watchdog. Worst case per byte is the longest send gap plus two
    // results each behind the longest stall; the limit covers that many times
    // over, drains included.
    localparam int PHASE_BYTES   = 150;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 400000;

    // Scoreboard: decodes every accepted byte into the results it must cause
    // and holds them in order until the output side delivers them.
    class transcode_scoreboard;
        result_t     awaited_results[$];
        logic [15:0] capacity;
        logic [1:0]  cont_left;
        logic [20:0] partial_cp;
        logic [15:0] units_out;
        bit          dropping;
        int          errors;

        function new();
            capacity  = CAP_RESET;
            cont_left = '0;
            partial_cp = '0;
            units_out = '0;
            dropping  = 1'b0;
            errors    = 0;
        endfunction

        function void set_capacity(logic [15:0] value);
            capacity = value;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void emit_unit(logic [15:0] unit);
            result_t r;
            units_out    = units_out + 16'd1;
            r.code_unit  = unit;
            r.status     = ST_UNIT;
            r.unit_count = units_out;
            r.last       = 1'b0;
            awaited_results.push_back(r);
        endfunction

        // Close the string with a status; drop the rest of it if asked.
        function void close_string(logic [1:0] st, bit drop_rest);
            result_t r;
            r.code_unit  = '0;
            r.status     = st;
            r.unit_count = units_out;
            r.last       = 1'b1;
            awaited_results.push_back(r);
            cont_left  = '0;
            partial_cp = '0;
            units_out  = '0;
            dropping   = drop_rest;
        endfunction

        function void decode_byte(logic [7:0] b);
            int          cap_eff;
            logic [20:0] cp;
            cap_eff = (capacity == 16'd0) ? 1 : int'(capacity);
            cp = '0;
            if (dropping)
            begin
                if (b == 8'h00)
                begin
                    dropping   = 1'b0;
                    cont_left  = '0;
                    partial_cp = '0;
                    units_out  = '0;
                end
                return;
            end
            if (cont_left == 2'd0)
            begin
                if (b == 8'h00)
                begin
                    close_string(ST_OK, 1'b0);
                    return;
                end
                // capacity is checked before the lead byte itself
                if (int'(units_out) + 1 >= cap_eff)
                begin
                    close_string(ST_TRUNC, 1'b1);
                    return;
                end
                if (b[7] == 1'b0)
                    cp = {13'd0, b};
                else if (b[7:5] == 3'b110)
                begin
                    partial_cp = {16'd0, b[4:0]};
                    cont_left  = 2'd1;
                    return;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    partial_cp = {17'd0, b[3:0]};
                    cont_left  = 2'd2;
                    return;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    partial_cp = {18'd0, b[2:0]};
                    cont_left  = 2'd3;
                    return;
                end
                else
                begin
                    close_string(ST_INVALID, 1'b1);
                    return;
                end
            end
            else
            begin
                // a zero byte here ends the string, so nothing is dropped
                if (b[7:6] != 2'b10)
                begin
                    close_string(ST_INVALID, b != 8'h00);
                    return;
                end
                partial_cp = {partial_cp[14:0], b[5:0]};
                cont_left  = cont_left - 2'd1;
                if (cont_left != 2'd0)
                    return;
                cp = partial_cp;
                partial_cp = '0;
            end

            if (cp <= BMP_LAST)
            begin
                if (cp >= SURR_FIRST && cp <= SURR_LAST)
                    close_string(ST_INVALID, 1'b1);
                else
                    emit_unit(cp[15:0]);
            end
            else if (cp <= CP_MAX)
            begin
                if (int'(units_out) + 2 >= cap_eff)
                    close_string(ST_TRUNC, 1'b1);
                else
                begin
                    cp = cp - SUPP_OFFSET;
                    emit_unit(HI_SURR_BASE | {6'd0, cp[19:10]});
                    emit_unit(LO_SURR_BASE | {6'd0, cp[9:0]});
                end
            end
            else
                close_string(ST_INVALID, 1'b1);
        endfunction

        function void report_field(string label, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
                         $time, label, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual %0h/%0d/%0d/%0b",
                         $time, got.code_unit, got.status, got.unit_count, got.last);
                return;
            end
            want = awaited_results.pop_front();
            report_field("code_unit", want.code_unit, got.code_unit);
            report_field("status", 16'(want.status), 16'(got.status));
            report_field("unit_count", want.unit_count, got.unit_count);
            report_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] code_unit;
    logic [1:0]  status;
    logic [15:0] unit_count;
    logic        last;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    transcode_scoreboard sb;
    logic [7:0] text_q[$];
    int         bytes_sent;
    int         cycles;
    bit         send_calm;
    bit         recv_calm;

    utf8_to_utf16_validating dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_unit   (code_unit),
        .status      (status),
        .unit_count  (unit_count),
        .last        (last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    // Watchdog: end the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output monitor: on every transfer, check against the oldest awaited result.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.code_unit  = code_unit;
            got.status     = status;
            got.unit_count = unit_count;
            got.last       = last;
            sb.check_result(got);
        end
    end

    // Output side: per result, stall a random number of cycles, then hold
    // ready until a transfer happens. With recv_calm set, keep ready high.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = recv_calm ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Present one byte after a random gap and hold it until the transfer.
    // Valid stays high across back-to-back bytes; this task only drops it on a gap.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        @(negedge clk);
        gap = send_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        do @(posedge clk); while (!in_ready);
        sb.decode_byte(value);
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_byte(text_q[i]);
    endtask

    // Drop valid and wait until every awaited result has arrived, then give
    // the input register the settle time to empty.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Change the capacity only with the block idle.
    task automatic write_capacity(input logic [15:0] value);
        drain_results();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_capacity(value);
    endtask

    function automatic void push_utf8(logic [20:0] cp, int nbytes);
        case (nbytes)
            1: text_q.push_back({1'b0, cp[6:0]});
            2:
            begin
                text_q.push_back({3'b110, cp[10:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                text_q.push_back({4'b1110, cp[15:12]});
                text_q.push_back({2'b10, cp[11:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                text_q.push_back({5'b11110, cp[20:18]});
                text_q.push_back({2'b10, cp[17:12]});
                text_q.push_back({2'b10, cp[11:6]});
                text_q.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // Build one random string: mostly well-formed characters of every length,
    // with some surrogates, out-of-range and overlong forms, stray bytes, cut
    // sequences and broken continuations mixed in.
    function automatic void build_random_text();
        int n;
        int kind;
        text_q.delete();
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
                push_utf8(21'($urandom_range(1, 127)), 1);
            else if (kind < 50)
                push_utf8(21'($urandom_range(0, 16'h07FF)), 2);
            else if (kind < 65)
            begin
                if (kind == 64)
                    push_utf8(21'($urandom_range(16'hD800, 16'hDFFF)), 3);
                else
                    push_utf8(21'($urandom_range(0, 16'hFFFF)), 3);
            end
            else if (kind < 80)
            begin
                if (kind <= 66)
                    push_utf8(21'($urandom_range(0, 21'h1FFFFF)), 4);
                else
                    push_utf8(21'($urandom_range(21'h010000, 21'h10FFFF)), 4);
            end
            else if (kind < 88)
                text_q.push_back(8'($urandom_range(1, 255)));
            else if (kind < 94)
            begin
                // four-byte sequence cut short; the next byte most often breaks it
                push_utf8(21'($urandom_range(21'h010000, 21'h10FFFF)), 4);
                repeat ($urandom_range(1, 3)) void'(text_q.pop_back());
            end
            else
            begin
                text_q.push_back({3'b110, 5'($urandom_range(0, 31))});
                text_q.push_back(8'($urandom_range(1, 127)));
            end
        end
        // leave a few strings open so they run on into the next one
        if ($urandom_range(0, 19) != 0)
            text_q.push_back(8'h00);
    endfunction

    initial
    begin
        int phase_caps[7];
        int phase_start;

        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_byte   = 8'h00;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 16'h0000;
        bytes_sent  = 0;
        cycles      = 0;
        send_calm   = 1'b0;
        recv_calm   = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset capacity of 256: ASCII top, a three-byte character
        // and the highest code point as a pair, an encoded surrogate with a
        // dropped tail, an all-ones lead, a code point past the maximum, a
        // zero byte inside a sequence, and a broken continuation.
        text_q = {8'h7F, 8'h00,
                  8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
                  8'hED, 8'hA0, 8'h80, 8'h41, 8'h00,
                  8'hFF, 8'h00,
                  8'hF4, 8'h90, 8'h80, 8'h80, 8'h00,
                  8'hC3, 8'h00,
                  8'hC3, 8'h41, 8'h00};
        send_text();

        // A pair that does not fit in a two-unit buffer.
        write_capacity(16'd2);
        text_q = {8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00};
        send_text();

        // Zero capacity behaves as one: the first byte truncates.
        write_capacity(16'd0);
        text_q = {8'h41, 8'h00};
        send_text();

        // Random phases over a spread of capacities, extremes included.
        phase_caps = '{65535, $urandom_range(4, 12), 3, 1, $urandom_range(13, 300), 2, 256};
        foreach (phase_caps[p])
        begin
            write_capacity(16'(phase_caps[p]));
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                send_calm = ($urandom_range(0, 3) == 0);
                recv_calm = ($urandom_range(0, 3) == 0);
                build_random_text();
                send_text();
                // now and then hold the input until the output side catches up
                if ($urandom_range(0, 24) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
